// File: design/ascii_integer_parser_macros.svh
// Assertion macros for the ASCII integer parser.
// Depends on clk and arst_n being visible at the point of use.
`ifndef ASCII_INTEGER_PARSER_MACROS_SVH
`define ASCII_INTEGER_PARSER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define AIP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define AIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/aip_pkg.sv
// Package for the ASCII integer parser: payload types, phase and width codes,
// register indexes and overflow limits. No dependencies.
`timescale 1ns / 1ps

package aip_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_VALUE_WIDTH    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_NEGATIVE = 1'b1;

	typedef enum logic [1:0] {
		WIDTH_8  = 2'd0,
		WIDTH_16 = 2'd1,
		WIDTH_32 = 2'd2
	} width_code_t;

	typedef enum logic [1:0] {
		PH_LEAD  = 2'd0,
		PH_DIGIT = 2'd1,
		PH_STOP  = 2'd2
	} phase_t;

	// Overflow limits and their quotients by each base
	localparam logic [31:0] LIM_8  = 32'h0000_00ff;
	localparam logic [31:0] LIM_16 = 32'h0000_ffff;
	localparam logic [31:0] LIM_32 = 32'hffff_ffff;

	localparam logic [31:0] LIM_8_DIV10  = LIM_8 / 10;
	localparam logic [31:0] LIM_16_DIV10 = LIM_16 / 10;
	localparam logic [31:0] LIM_32_DIV10 = LIM_32 / 10;
	localparam logic [31:0] LIM_8_DIV16  = LIM_8 / 16;
	localparam logic [31:0] LIM_16_DIV16 = LIM_16 / 16;
	localparam logic [31:0] LIM_32_DIV16 = LIM_32 / 16;

	typedef struct packed {
		logic plus;
		logic minus;
		logic hex;
		logic extra;
		logic overflow;
		logic valid;
	} flags_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value;
		logic        flag_plus;
		logic        flag_minus;
		logic        flag_hex;
		logic        flag_extra;
		logic        flag_overflow;
		logic        flag_valid;
		logic        accepted;
	} out_item_t;

endpackage

// File: design/aip_stream_if.sv
// Valid/ready stream interfaces for the ASCII integer parser.
// Depends on aip_pkg for the payload types.
`timescale 1ns / 1ps

interface aip_in_if import aip_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aip_out_if import aip_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/ascii_integer_parser.sv
// Channel      Dir  Payload                               Request moves
// char_in      in   ch[7:0], end_of_text                  one character or end mark
// result_out   out  value[31:0], six flags, accepted      one parsed number
// cfg          in   cfg_we, cfg_index[0:0], cfg_data[1:0] one register write
//
// One character per cycle unless an end mark is held; an end mark's result is loaded
// by way of the input register, then the result register.
// The input register feeds the per-character parse step (constant multiply,
// add and limit compare) straight into the number state, which loads the result register.
// A result waiting on result_out stalls only an end mark behind it; plain
// characters keep flowing. Reset clears the number state and sets
// value_width to 32 bits and allow_negative to 0.
// Depends on aip_pkg, aip_stream_if and ascii_integer_parser_macros.svh.
`timescale 1ns / 1ps
`include "ascii_integer_parser_macros.svh"

module ascii_integer_parser import aip_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	aip_in_if.sink                char_in,
	aip_out_if.source             result_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;

	// Configuration registers
	logic [1:0] value_width_q;
	logic       allow_negative_q;

	// Input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       eot_s1;
	logic       adv_s1;

	// Number state
	phase_t      phase_q, phase_d;
	logic        zero_seen_q, zero_seen_d;
	logic        hex_mode_q, hex_mode_d;
	logic [31:0] acc_q, acc_d;
	flags_t      flags_q, flags_d;

	// Result register
	logic      out_valid_q;
	out_item_t out_q;

	// Per-character step signals
	logic [31:0] lim;
	logic [31:0] lim_div;
	logic [31:0] prod;
	logic [32:0] sum;
	logic [3:0]  digit;
	logic        is_digit;
	logic        take;
	logic [7:0]  c;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_width_q    <= WIDTH_32;
			allow_negative_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VALUE_WIDTH:    value_width_q    <= cfg_data;
				REG_ALLOW_NEGATIVE: allow_negative_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance the input register unless an end mark waits on a full result register
	assign adv_s1        = valid_s1 && (!eot_s1 || !out_valid_q || result_out.ready);
	assign char_in.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.ready) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.ready && char_in.valid) begin
			ch_s1  <= char_in.data.ch;
			eot_s1 <= char_in.data.end_of_text;
		end
	end

	// Select overflow limit and its quotient by the current base
	always_comb begin
		case (value_width_q)
			WIDTH_16: begin
				lim     = LIM_16;
				lim_div = hex_mode_q ? LIM_16_DIV16 : LIM_16_DIV10;
			end
			WIDTH_32: begin
				lim     = LIM_32;
				lim_div = hex_mode_q ? LIM_32_DIV16 : LIM_32_DIV10;
			end
			default: begin
				lim     = LIM_8;
				lim_div = hex_mode_q ? LIM_8_DIV16 : LIM_8_DIV10;
			end
		endcase
	end

	// Decode digit and form the shifted accumulator
	assign c    = ch_s1;
	assign prod = hex_mode_q ? {acc_q[27:0], 4'd0} : ({acc_q[28:0], 3'd0} + {acc_q[30:0], 1'b0});
	assign sum  = {1'b0, prod} + {29'd0, digit};

	always_comb begin
		digit    = 4'd0;
		is_digit = 1'b0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			digit    = 4'(c - CH_ZERO);
			is_digit = 1'b1;
		end else if (hex_mode_q && c >= CH_UP_A && c <= CH_UP_F) begin
			digit    = 4'(c - CH_UP_A + 8'd10);
			is_digit = 1'b1;
		end else if (hex_mode_q && c >= CH_LOW_A && c <= CH_LOW_F) begin
			digit    = 4'(c - CH_LOW_A + 8'd10);
			is_digit = 1'b1;
		end
	end

	// Next number state for one character
	always_comb begin
		phase_d     = phase_q;
		zero_seen_d = zero_seen_q;
		hex_mode_d  = hex_mode_q;
		acc_d       = acc_q;
		flags_d     = flags_q;
		take        = 1'b0;

		case (phase_q)
			PH_LEAD: begin
				if (c == CH_ZERO) begin
					zero_seen_d   = 1'b1;
					flags_d.valid = 1'b1;
				end else if (c > CH_SPACE) begin
					phase_d = PH_DIGIT;
					if (c == CH_PLUS) begin
						flags_d.plus = 1'b1;
					end else if (c == CH_MINUS) begin
						flags_d.minus = 1'b1;
					end else if ((c == CH_LOW_X || c == CH_UP_X) && zero_seen_q) begin
						flags_d.hex = 1'b1;
						hex_mode_d  = 1'b1;
					end else begin
						take = 1'b1;
					end
				end
			end
			PH_DIGIT: take = 1'b1;
			default: ;
		endcase

		// Accumulate a digit, or stop on a non-digit or overflow
		if (take) begin
			if (!is_digit) begin
				flags_d.extra = 1'b1;
				phase_d       = PH_STOP;
			end else if (acc_q > lim_div) begin
				flags_d.overflow = 1'b1;
				flags_d.extra    = 1'b1;
				phase_d          = PH_STOP;
			end else begin
				flags_d.valid = 1'b1;
				if (sum > {1'b0, lim}) begin
					flags_d.overflow = 1'b1;
					flags_d.extra    = 1'b1;
					acc_d            = prod;
					phase_d          = PH_STOP;
				end else begin
					acc_d = sum[31:0];
				end
			end
		end
	end

	// Update number state; clear it once an end mark is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			zero_seen_q <= 1'b0;
			hex_mode_q  <= 1'b0;
			acc_q       <= '0;
			flags_q     <= '0;
		end else if (adv_s1) begin
			if (eot_s1) begin
				phase_q     <= PH_LEAD;
				zero_seen_q <= 1'b0;
				hex_mode_q  <= 1'b0;
				acc_q       <= '0;
				flags_q     <= '0;
			end else begin
				phase_q     <= phase_d;
				zero_seen_q <= zero_seen_d;
				hex_mode_q  <= hex_mode_d;
				acc_q       <= acc_d;
				flags_q     <= flags_d;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && eot_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && eot_s1) begin
			out_q.value         <= flags_q.minus ? (~acc_q + 32'd1) : acc_q;
			out_q.flag_plus     <= flags_q.plus;
			out_q.flag_minus    <= flags_q.minus;
			out_q.flag_hex      <= flags_q.hex;
			out_q.flag_extra    <= flags_q.extra;
			out_q.flag_overflow <= flags_q.overflow;
			out_q.flag_valid    <= flags_q.valid;
			out_q.accepted      <= flags_q.valid && !flags_q.extra && !flags_q.overflow &&
				(allow_negative_q || !flags_q.minus);
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.data  = out_q;

	`AIP_ASSERT_NOW(a_accept_clean, out_valid_q && out_q.accepted,
		out_q.flag_valid && !out_q.flag_extra && !out_q.flag_overflow,
		"accepted result carries an error flag")
	`AIP_ASSERT_NOW(a_ovf_extra, out_valid_q && out_q.flag_overflow, out_q.flag_extra,
		"overflow without extra-data")
	`AIP_ASSERT_NEXT(a_clear_after_end, adv_s1 && eot_s1,
		phase_q == PH_LEAD && acc_q == 32'd0 && flags_q == '0 && out_valid_q,
		"number state not cleared after end mark")
	`AIP_ASSERT_NEXT(a_stop_holds, phase_q == PH_STOP && !(adv_s1 && eot_s1),
		phase_q == PH_STOP && $stable(acc_q),
		"stopped number changed before end mark")

endmodule

// File: tb/sv/aip_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the ASCII integer parser: follows accepted characters and
// register writes, predicts each parsed number and compares it on result_out.
// Depends on aip_pkg and the stream interfaces of aip_stream_if.

module aip_result_checker import aip_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	aip_in_if                     char_in,
	aip_out_if                    result_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    numbers_seen,
	output int                    numbers_pending
);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_X_LO  = "x";
	localparam logic [7:0] CH_X_UP  = "X";
	localparam logic [7:0] CH_A_LO  = "a";
	localparam logic [7:0] CH_F_LO  = "f";
	localparam logic [7:0] CH_A_UP  = "A";
	localparam logic [7:0] CH_F_UP  = "F";

	// Register copies and the number being parsed
	logic [1:0]  width_reg;
	logic        allow_neg;
	phase_t      num_phase;
	logic        zero_seen;
	logic        hex_mode;
	logic [31:0] acc;
	flags_t      fl;

	out_item_t expected_numbers[$];
	int        err_count;
	int        checked;

	function automatic logic [31:0] width_limit();
		case (width_reg)
			WIDTH_32: return LIM_32;
			WIDTH_16: return LIM_16;
			default:  return LIM_8;
		endcase
	endfunction

	task automatic clear_number();
		num_phase = PH_LEAD;
		zero_seen = 1'b0;
		hex_mode  = 1'b0;
		acc       = '0;
		fl        = '0;
	endtask

	// Accumulate one digit; stop on a non-digit or when the limit is exceeded
	task automatic take_digit(input logic [7:0] c);
		logic [31:0] base;
		logic [31:0] lim;
		logic [31:0] d;
		logic [7:0]  u;
		logic        is_digit;
		base     = hex_mode ? 32'd16 : 32'd10;
		lim      = width_limit();
		u        = c;
		d        = '0;
		is_digit = 1'b1;
		if (hex_mode && c >= CH_A_LO && c <= CH_F_LO)
			u = c - CH_A_LO + CH_A_UP;
		if (u >= CH_ZERO && u <= CH_NINE)
			d = 32'(u - CH_ZERO);
		else if (hex_mode && u >= CH_A_UP && u <= CH_F_UP)
			d = 32'(u - CH_A_UP) + 32'd10;
		else
			is_digit = 1'b0;

		if (!is_digit) begin
			fl.extra  = 1'b1;
			num_phase = PH_STOP;
		end else if (acc > lim / base) begin
			fl.overflow = 1'b1;
			fl.extra    = 1'b1;
			num_phase   = PH_STOP;
		end else begin
			fl.valid = 1'b1;
			if (d > lim - acc * base) begin
				fl.overflow = 1'b1;
				fl.extra    = 1'b1;
				acc         = acc * base;
				num_phase   = PH_STOP;
			end else begin
				acc = acc * base + d;
			end
		end
	endtask

	// Leading phase skips blanks and zeros and takes a sign or a hex prefix
	task automatic take_char(input logic [7:0] c);
		if (num_phase == PH_LEAD) begin
			if (c == CH_ZERO) begin
				zero_seen = 1'b1;
				fl.valid  = 1'b1;
			end else if (c > CH_SPACE) begin
				num_phase = PH_DIGIT;
				if (c == CH_PLUS) begin
					fl.plus = 1'b1;
				end else if (c == CH_MINUS) begin
					fl.minus = 1'b1;
				end else if ((c == CH_X_LO || c == CH_X_UP) && zero_seen) begin
					fl.hex   = 1'b1;
					hex_mode = 1'b1;
				end else begin
					take_digit(c);
				end
			end
		end else if (num_phase == PH_DIGIT) begin
			take_digit(c);
		end
	endtask

	// Close the number: queue its expected result and start over
	task automatic close_number();
		out_item_t r;
		r.value         = fl.minus ? 32'd0 - acc : acc;
		r.flag_plus     = fl.plus;
		r.flag_minus    = fl.minus;
		r.flag_hex      = fl.hex;
		r.flag_extra    = fl.extra;
		r.flag_overflow = fl.overflow;
		r.flag_valid    = fl.valid;
		r.accepted      = fl.valid && !fl.extra && !fl.overflow && (allow_neg || !fl.minus);
		expected_numbers.push_back(r);
		clear_number();
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			err_count++;
			if (err_count <= 10)
				$display("Mismatch in number %0d, %s: expected %h, got %h",
					checked, field, want, got);
		end
	endtask

	task automatic compare_number(input out_item_t got);
		out_item_t want;
		if (expected_numbers.size() == 0) begin
			err_count++;
			if (err_count <= 10)
				$display("Unexpected result with value %h", got.value);
		end else begin
			want = expected_numbers.pop_front();
			check_field("value", want.value, got.value);
			check_field("flag_plus", 32'(want.flag_plus), 32'(got.flag_plus));
			check_field("flag_minus", 32'(want.flag_minus), 32'(got.flag_minus));
			check_field("flag_hex", 32'(want.flag_hex), 32'(got.flag_hex));
			check_field("flag_extra", 32'(want.flag_extra), 32'(got.flag_extra));
			check_field("flag_overflow", 32'(want.flag_overflow), 32'(got.flag_overflow));
			check_field("flag_valid", 32'(want.flag_valid), 32'(got.flag_valid));
			check_field("accepted", 32'(want.accepted), 32'(got.accepted));
			checked++;
		end
	endtask

	// Follow register writes, characters and results at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = WIDTH_32;
			allow_neg = 1'b0;
			clear_number();
			expected_numbers.delete();
			err_count = 0;
			checked   = 0;
			mismatches      <= 0;
			numbers_seen    <= 0;
			numbers_pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_VALUE_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == REG_ALLOW_NEGATIVE)
					allow_neg = cfg_data[0];
			end
			if (char_in.valid && char_in.ready) begin
				if (char_in.data.end_of_text)
					close_number();
				else
					take_char(char_in.data.ch);
			end
			if (result_out.valid && result_out.ready)
				compare_number(result_out.data);
			mismatches      <= err_count;
			numbers_seen    <= checked;
			numbers_pending <= expected_numbers.size();
		end
	end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the ASCII integer parser testbench: clock, reset, character stimulus,
// register writes and result backpressure; checking is in aip_result_checker.
// Depends on aip_pkg, aip_stream_if, ascii_integer_parser and aip_result_checker.

module tb_top;
	import aip_pkg::*;

	localparam logic [1:0] WIDTH_SPARE   = 2'd3;
	localparam int         SETTLE_CYCLES = 4;
	localparam int         PHASE_CHARS   = 125;
	localparam int         NUM_PHASES    = 8;
	localparam logic [7:0] BYTE_NUL      = 8'h00;
	localparam logic [7:0] BYTE_TOP      = 8'hff;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	in_item_t              in_data      = '0;
	logic                  result_ready = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	aip_in_if  char_in ();
	aip_out_if result_out ();

	assign char_in.valid    = in_valid;
	assign char_in.data     = in_data;
	assign result_out.ready = result_ready;

	int         mismatches;
	int         numbers_seen;
	int         numbers_pending;
	int         chars_sent;
	int         settings_used;
	int         free_in;
	int         stall_left;
	int         free_out;
	logic [1:0] cur_width;

	ascii_integer_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.result_out (result_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	aip_result_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_in         (char_in),
		.result_out      (result_out),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.numbers_seen    (numbers_seen),
		.numbers_pending (numbers_pending)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Stall the result side at random, with stretches of no stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left = 0;
			free_out   = 0;
		end else if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left--;
		end else begin
			result_ready <= 1'b1;
			if (free_out > 0)
				free_out--;
			else if ($urandom_range(0, 99) < 3)
				free_out = $urandom_range(20, 80);
			else if ($urandom_range(0, 99) < 30)
				stall_left = gap_len();
		end
	end

	// Offer one request after an optional gap and hold it until accepted
	task automatic send_item(input logic [7:0] c, input logic eot);
		int gap;
		gap = 0;
		if (free_in > 0)
			free_in--;
		else if ($urandom_range(0, 99) < 2)
			free_in = $urandom_range(20, 60);
		else if ($urandom_range(0, 99) < 35)
			gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{ch: c, end_of_text: eot};
		@(posedge clk);
		while (!char_in.ready) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic end_text();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Hold the sender until every result is back and the pipeline is empty
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (numbers_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [1:0] width, input logic allow);
		wait_idle();
		write_reg(REG_VALUE_WIDTH, width);
		write_reg(REG_ALLOW_NEGATIVE, CFG_DATA_W'(allow));
		cur_width = width;
		settings_used++;
	endtask

	// Mostly well-formed numbers with random content, some near the limit,
	// some with junk after the digits, and some pure noise
	task automatic send_random_number();
		string       body;
		string       digit_set;
		int          kind;
		int          n;
		int          max_digits;
		logic        hex;
		logic [63:0] lim;
		logic [63:0] v;
		logic [7:0]  c;
		digit_set = "0123456789abcdefABCDEF";
		body      = "";
		kind      = $urandom_range(0, 99);
		case (cur_width)
			WIDTH_32: lim = 64'(LIM_32);
			WIDTH_16: lim = 64'(LIM_16);
			default:  lim = 64'(LIM_8);
		endcase
		if (kind < 10) begin
			repeat ($urandom_range(0, 8)) send_item(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			hex = ($urandom_range(0, 2) == 0);
			repeat ($urandom_range(0, 2)) send_item(8'($urandom_range(0, 32)), 1'b0);
			n = $urandom_range(0, 2);
			if (hex && n == 0)
				n = 1;
			repeat (n) send_text("0");
			if (hex)
				send_text($urandom_range(0, 1) ? "x" : "X");
			else if ($urandom_range(0, 2) == 0)
				send_text($urandom_range(0, 1) ? "+" : "-");

			if (kind < 30) begin
				v = lim + 64'($urandom_range(0, 4)) - 64'd2;
				body = hex ? $sformatf("%0h", v) : $sformatf("%0d", v);
				for (int i = 0; i < body.len(); i++) begin
					c = body[i];
					if (c >= "a" && $urandom_range(0, 1))
						c = c - 8'h20;
					send_item(c, 1'b0);
				end
			end else begin
				case (cur_width)
					WIDTH_32: max_digits = hex ? 8 : 10;
					WIDTH_16: max_digits = hex ? 4 : 5;
					default:  max_digits = hex ? 2 : 3;
				endcase
				repeat ($urandom_range(0, max_digits + 1))
					send_item(digit_set[$urandom_range(0, hex ? 21 : 9)], 1'b0);
			end

			if ($urandom_range(0, 99) < 12)
				repeat ($urandom_range(1, 3))
					send_item(8'($urandom_range(0, 255)), 1'b0);
		end
		end_text();
	endtask

	// Stimulus
	initial begin
		logic [1:0] width_plan [NUM_PHASES];
		logic       allow_plan [NUM_PHASES];
		int         phase_start;
		width_plan = '{WIDTH_8, WIDTH_32, WIDTH_16, WIDTH_SPARE,
			WIDTH_32, WIDTH_16, WIDTH_8, WIDTH_SPARE};
		allow_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
		chars_sent    = 0;
		settings_used = 0;
		free_in       = 0;
		cur_width     = WIDTH_32;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 32-bit limit, negatives refused
		end_text();
		send_item(BYTE_NUL, 1'b0);
		send_text("00");
		end_text();
		send_text("-12");
		end_text();
		send_text("0xfF");
		end_text();
		send_text("+5z");
		send_item(BYTE_TOP, 1'b0);
		end_text();

		// Change the limit in the middle of a number
		send_text("25");
		set_config(WIDTH_8, 1'b1);
		send_text("6");
		end_text();
		send_text("-7");
		end_text();
		set_config(WIDTH_SPARE, 1'b0);
		send_text("300");
		end_text();

		// Random numbers under each planned register setting
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_config(width_plan[p], allow_plan[p]);
			phase_start = chars_sent;
			while (chars_sent - phase_start < PHASE_CHARS) begin
				send_random_number();
				if ($urandom_range(0, 39) == 0)
					wait_idle();
			end
		end

		// Drain
		wait_idle();
		repeat (8) @(posedge clk);

		$display("Checked %0d parsed numbers from %0d characters under %0d register settings",
			numbers_seen, chars_sent, settings_used);
		if (numbers_pending != 0)
			$display("%0d expected numbers never arrived", numbers_pending);
		if (mismatches == 0 && numbers_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Timed out waiting for the parser");
		$display("Some tests failed");
		$finish;
	end

endmodule
